### sv/idxsa_pkg.sv
// idxsa_pkg: shared constants and types for the indexed shift array
// operation and status codes, default sizes, cell control struct
// no dependencies
`timescale 1ns / 1ps

package idxsa_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_INSERT    = 2'd0;
   localparam logic [1:0] OP_ERASE     = 2'd1;
   localparam logic [1:0] OP_OVERWRITE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_POS = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // broadcast to every cell; flags are already qualified by accept and range checks
   typedef struct packed {
      logic insert;
      logic erase;
      logic overwrite;
   } cell_ctrl_type;

endpackage

### sv/idxsa_cell.sv
// idxsa_cell: one storage cell of the indexed shift array
// shifts up from its lower neighbor, down from its upper neighbor, or loads the item value
// depends on idxsa_pkg
`timescale 1ns / 1ps

module idxsa_cell #(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = idxsa_pkg::DATA_WIDTH_DEF,
   parameter int POS_WIDTH  = 5
) (
   input  logic                       clock,
   input  idxsa_pkg::cell_ctrl_type   ctrl,
   input  logic [POS_WIDTH-1:0]       pos,
   input  logic [DATA_WIDTH-1:0]      value,
   input  logic [DATA_WIDTH-1:0]      lower_data,
   input  logic [DATA_WIDTH-1:0]      upper_data,
   output logic [DATA_WIDTH-1:0]      data
);

   localparam logic [POS_WIDTH-1:0] IDX = POS_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.insert) begin
         if (IDX > pos) begin
            data_in = lower_data;
         end else if (IDX == pos) begin
            data_in = value;
         end
      end else if (ctrl.erase) begin
         if (IDX >= pos) begin
            data_in = upper_data;
         end
      end else if (ctrl.overwrite) begin
         if (IDX == pos) begin
            data_in = value;
         end
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### sv/indexed_shift_array.sv
// indexed_shift_array: ordered array with insert, erase and overwrite at an index
// top level: request decode, element count, a row of idxsa_cell, result register
// depends on idxsa_pkg and idxsa_cell
//
// channel  | dir | handshake             | payload
// ---------+-----+-----------------------+-------------------------------------------
// req      | in  | req_tvalid/req_tready | tdata: position, value; tuser: operation
// rsp      | out | rsp_tvalid/rsp_tready | tdata: removed_value, count, status
//
// every item is decoded and applied to all cells in the cycle it is accepted; the
// result is registered and shows in the next cycle, so one item per cycle is sustained
// while the result is not stalled; the rate is set by the parallel shift of the cell row.
// reset clears the count and the result valid; cell contents are not cleared.
// a stalled result holds req_tready low until it is taken or taken in the same cycle.
`timescale 1ns / 1ps

module indexed_shift_array #(
   parameter int DEPTH      = idxsa_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = idxsa_pkg::DATA_WIDTH_DEF,
   localparam int CW        = $clog2(DEPTH + 1),
   localparam int REQ_W     = ((CW + DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W     = ((DATA_WIDTH + CW + 2 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // position, value, zero pad
   input  logic [1:0]       req_tuser,   // operation
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // removed_value, count, status, zero pad
);

   localparam int IW = $clog2(DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic                  accept;
   logic [1:0]            op;
   logic [CW-1:0]         pos;
   logic [DATA_WIDTH-1:0] val;

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] removed_ff;
   logic [DATA_WIDTH-1:0] removed_in;
   logic [1:0]            status_ff;
   logic [1:0]            status_in;

   idxsa_pkg::cell_ctrl_type ctrl;

   logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
   logic [DATA_WIDTH-1:0] lower_data [DEPTH];
   logic [DATA_WIDTH-1:0] upper_data [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign op  = req_tuser;
   assign pos = req_tdata[CW-1:0];
   assign val = req_tdata[CW +: DATA_WIDTH];

   always_comb begin
      ctrl       = '0;
      count_in   = count_ff;
      removed_in = '0;
      status_in  = idxsa_pkg::ST_OK;
      case (op)
         idxsa_pkg::OP_INSERT: begin
            if (pos > count_ff) begin
               status_in = idxsa_pkg::ST_BAD_POS;
            end else if (count_ff >= FULL_COUNT) begin
               status_in = idxsa_pkg::ST_FULL;
            end else begin
               ctrl.insert = accept;
               count_in    = count_ff + CW'(1);
            end
         end
         idxsa_pkg::OP_ERASE: begin
            if (pos >= count_ff) begin
               status_in = idxsa_pkg::ST_BAD_POS;
            end else begin
               ctrl.erase = accept;
               removed_in = cell_data[pos[IW-1:0]];
               count_in   = count_ff - CW'(1);
            end
         end
         idxsa_pkg::OP_OVERWRITE: begin
            if (pos >= count_ff) begin
               status_in = idxsa_pkg::ST_BAD_POS;
            end else begin
               ctrl.overwrite = accept;
            end
         end
         default: begin
            // unused code: no change, ok status
            status_in = idxsa_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         removed_ff <= removed_in;
         status_ff  <= status_in;
      end
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_lo
            assign lower_data[i] = '0;
         end else begin : g_lo
            assign lower_data[i] = cell_data[i-1];
         end
         if (i == DEPTH - 1) begin : g_hi
            assign upper_data[i] = '0;
         end else begin : g_hi
            assign upper_data[i] = cell_data[i+1];
         end

         idxsa_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH),
            .POS_WIDTH  (CW)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .pos        (pos),
            .value      (val),
            .lower_data (lower_data[i]),
            .upper_data (upper_data[i]),
            .data       (cell_data[i])
         );
      end
   endgenerate

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                           = '0;
      rsp_tdata[DATA_WIDTH-1:0]           = removed_ff;
      rsp_tdata[DATA_WIDTH +: CW]         = count_ff;
      rsp_tdata[DATA_WIDTH + CW +: 2]     = status_ff;
   end

endmodule

### tb/sv/tb.sv
// tb: self-checking bench for indexed_shift_array, insert / erase / overwrite at an index
// drives a directed table then random phases with idling, checks each result item in order
// depends on idxsa_pkg and indexed_shift_array
`timescale 1ns / 1ps

module tb;

   localparam int ARRAY_DEPTH      = idxsa_pkg::DEPTH_DEF;
   localparam logic [1:0] OP_INSERT    = idxsa_pkg::OP_INSERT;
   localparam logic [1:0] OP_ERASE     = idxsa_pkg::OP_ERASE;
   localparam logic [1:0] OP_OVERWRITE = idxsa_pkg::OP_OVERWRITE;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] ST_OK      = idxsa_pkg::ST_OK;
   localparam logic [1:0] ST_BAD_POS = idxsa_pkg::ST_BAD_POS;
   localparam logic [1:0] ST_FULL    = idxsa_pkg::ST_FULL;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int ITEMS_PER_PHASE  = 130;
   localparam int NUM_ROWS         = 19;

   typedef struct packed {
      logic [31:0] removed;
      logic [4:0]  count;
      logic [1:0]  status;
   } array_reply_type;

   typedef struct packed {
      logic [1:0]      op;
      logic [4:0]      pos;
      logic [31:0]     val;
      logic [4:0]      reps;
      logic            typed;
      array_reply_type reply;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [39:0] req_tdata  = '0;   // position, value, zero pad
   logic [1:0]  req_tuser  = '0;   // operation
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [39:0] rsp_tdata;         // removed_value, count, status, zero pad

   // shadow copy of the array contents and count
   logic [31:0]     shadow_elems [ARRAY_DEPTH];
   int              shadow_count = 0;
   array_reply_type expected_replies [$];
   int              mismatch_count = 0;

   int  req_idle_pct  = 0;
   int  rsp_stall_pct = 0;
   bit  long_hold_req  = 1'b0;
   bit  long_hold_done = 1'b0;
   int  hold_left      = 0;

   // typed rows hold results readable at a glance; others go through the predictor
   directed_row_type directed_rows [NUM_ROWS] = '{
      '{OP_ERASE,     5'd0,  32'h0,        5'd1,  1'b1, '{32'h0,        5'd0,  ST_BAD_POS}},
      '{OP_OVERWRITE, 5'd0,  32'hffffffff, 5'd1,  1'b1, '{32'h0,        5'd0,  ST_BAD_POS}},
      '{OP_UNUSED,    5'd31, 32'hffffffff, 5'd1,  1'b1, '{32'h0,        5'd0,  ST_OK}},
      '{OP_INSERT,    5'd1,  32'h0,        5'd1,  1'b1, '{32'h0,        5'd0,  ST_BAD_POS}},
      '{OP_INSERT,    5'd0,  32'hffffffff, 5'd1,  1'b1, '{32'h0,        5'd1,  ST_OK}},
      '{OP_INSERT,    5'd1,  32'h0,        5'd1,  1'b1, '{32'h0,        5'd2,  ST_OK}},
      '{OP_INSERT,    5'd0,  32'ha5a5a5a5, 5'd1,  1'b1, '{32'h0,        5'd3,  ST_OK}},
      '{OP_OVERWRITE, 5'd2,  32'h5a5a5a5a, 5'd1,  1'b1, '{32'h0,        5'd3,  ST_OK}},
      '{OP_OVERWRITE, 5'd3,  32'h0,        5'd1,  1'b1, '{32'h0,        5'd3,  ST_BAD_POS}},
      '{OP_ERASE,     5'd1,  32'h0,        5'd1,  1'b1, '{32'hffffffff, 5'd2,  ST_OK}},
      '{OP_ERASE,     5'd31, 32'h0,        5'd1,  1'b1, '{32'h0,        5'd2,  ST_BAD_POS}},
      '{OP_INSERT,    5'd31, 32'h0,        5'd1,  1'b1, '{32'h0,        5'd2,  ST_BAD_POS}},
      // fill up to full by inserting in the middle
      '{OP_INSERT,    5'd1,  32'h00010000, 5'd14, 1'b0, '{32'h0,        5'd0,  ST_OK}},
      '{OP_INSERT,    5'd16, 32'hffffffff, 5'd1,  1'b1, '{32'h0,        5'd16, ST_FULL}},
      // bad position wins over full
      '{OP_INSERT,    5'd17, 32'h0,        5'd1,  1'b1, '{32'h0,        5'd16, ST_BAD_POS}},
      '{OP_INSERT,    5'd0,  32'h0,        5'd1,  1'b1, '{32'h0,        5'd16, ST_FULL}},
      '{OP_OVERWRITE, 5'd15, 32'h0,        5'd1,  1'b0, '{32'h0,        5'd0,  ST_OK}},
      '{OP_ERASE,     5'd15, 32'h0,        5'd1,  1'b0, '{32'h0,        5'd0,  ST_OK}},
      '{OP_ERASE,     5'd0,  32'h0,        5'd1,  1'b0, '{32'h0,        5'd0,  ST_OK}}
   };

   indexed_shift_array DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // applies one request to the shadow array and returns the result it gives
   function automatic array_reply_type shift_array_predict(logic [1:0] op, logic [4:0] pos,
                                                           logic [31:0] val);
      array_reply_type r;
      int              p;
      int              j;
      r = '0;
      r.status = ST_OK;
      p = int'(pos);
      case (op)
         OP_INSERT: begin
            if (p > shadow_count) begin
               r.status = ST_BAD_POS;
            end else if (shadow_count >= ARRAY_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (j = shadow_count; j > p; j--) shadow_elems[j] = shadow_elems[j - 1];
               shadow_elems[p] = val;
               shadow_count++;
            end
         end
         OP_ERASE: begin
            if (p >= shadow_count) begin
               r.status = ST_BAD_POS;
            end else begin
               r.removed = shadow_elems[p];
               for (j = p; j + 1 < shadow_count; j++) shadow_elems[j] = shadow_elems[j + 1];
               shadow_count--;
            end
         end
         OP_OVERWRITE: begin
            if (p >= shadow_count) r.status = ST_BAD_POS;
            else shadow_elems[p] = val;
         end
         default: begin
         end
      endcase
      r.count = shadow_count[4:0];
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic send_item(logic [1:0] op, logic [4:0] pos, logic [31:0] val, bit typed,
                            array_reply_type typed_reply);
      array_reply_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, val, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = shift_array_predict(op, pos, val);
      expected_replies.push_back(typed ? typed_reply : predicted);
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_left      <= LONG_HOLD_CYCLES;
         rsp_tready     <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_replies
      array_reply_type got;
      array_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[36:32], rsp_tdata[38:37]};
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("result item with none pending: %h", got));
         end else begin
            want = expected_replies.pop_front();
            if (got.removed !== want.removed)
               report_mismatch($sformatf("removed_value %h, want %h", got.removed, want.removed));
            if (got.count !== want.count)
               report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         end
      end
   end

   initial begin : stimulus
      directed_row_type row;
      int               phase;
      int               i;
      int               k;
      int               roll;
      int               fill_bias;
      logic [1:0]       op;
      logic [4:0]       pos;
      logic [31:0]      val;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_ROWS; i++) begin
         row = directed_rows[i];
         for (k = 0; k < row.reps; k++)
            send_item(row.op, row.pos, 32'(row.val + k), row.typed, row.reply);
      end
      drain_replies();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
               // sender keeps offering while the receiver holds off
               long_hold_req = 1'b1;
            end
            1: begin
               req_idle_pct  = 77;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 77;
            end
            default: begin
               req_idle_pct  = 28;
               rsp_stall_pct = 28;
            end
         endcase

         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            // alternate filling and draining runs so both full and empty are reached
            fill_bias = ((i / 20) % 2 == 0) ? 70 : 30;
            val  = $urandom();
            roll = $urandom_range(99);
            if (roll < 5) val = '1;
            else if (roll < 10) val = '0;
            roll = $urandom_range(99);
            if (roll < 12) begin
               op  = 2'($urandom_range(3));
               pos = 5'($urandom_range(31));
            end else begin
               roll = $urandom_range(99);
               if (roll < fill_bias) begin
                  op  = OP_INSERT;
                  pos = 5'($urandom_range(shadow_count));
               end else begin
                  op  = (roll < fill_bias + (100 - fill_bias) * 3 / 4) ? OP_ERASE : OP_OVERWRITE;
                  pos = (shadow_count == 0) ? 5'd0 : 5'($urandom_range(shadow_count - 1));
               end
            end
            send_item(op, pos, val, 1'b0, '0);
         end
         drain_replies();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
